// ===== hw/rtl/matrix_vector_multiply_macros.svh =====
// assertion helpers for the matrix_vector_multiply rtl
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// same-cycle implication, held off during reset
`define MVM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mvm_pkg.sv =====
`default_nettype none

package mvm_pkg;

    // default storage shape
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // field widths
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int CNT_W  = 7;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register reset values
    localparam logic [CNT_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CNT_W-1:0] COLS_RESET = 7'd64;

    // register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // command codes
    localparam logic CMD_WEIGHT_ADD  = 1'b0;
    localparam logic CMD_VECTOR_LOAD = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WWR,
        ST_MAC,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    // clamp a 17-bit sum into the signed 16-bit range
    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [VAL_W:0] sum);
        logic signed [VAL_W-1:0] res;
        if (sum > 17'sd32767) begin
            res = 16'sh7fff;
        end else if (sum < -17'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = sum[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_vector_multiply.sv =====
`default_nettype none
// Dense matrix-vector multiply with a stored Q4.12 weight matrix and one
// shared multiply-accumulate unit. After reset a clearing pass zeroes the
// weight memory, one entry a cycle; s_ready stays low meanwhile,
// configuration writes are taken. A weight add item is read, then its
// saturated sum is written back through the single weight memory write
// port. A last vector element starts the multiply: each row streams its
// columns through the one MAC at one column a cycle, and m_ready can hold
// off the output register before the next row. Results come out in row
// order as Q16.24 in 40 bits.
`include "matrix_vector_multiply_macros.svh"

module matrix_vector_multiply #(
    parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mvm_pkg::APB_AW-1:0]        paddr,
    input  wire logic [mvm_pkg::APB_DW-1:0]        pwdata,
    output logic      [mvm_pkg::APB_DW-1:0]        prdata,
    output logic                                   pready,
    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_command,
    input  wire logic [mvm_pkg::ROW_W-1:0]         s_row_index,
    input  wire logic [mvm_pkg::COL_W-1:0]         s_col_index,
    input  wire logic signed [mvm_pkg::VAL_W-1:0]  s_value,
    input  wire logic                              s_vector_last,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [mvm_pkg::ROW_W-1:0]         m_out_row,
    output logic signed [mvm_pkg::ACC_W-1:0]       m_out_value,
    output logic                                   m_out_last
);
    import mvm_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int ROW_LIM = (MAX_ROWS > CNT_MAX) ? CNT_MAX : MAX_ROWS;
    localparam int COL_LIM = (MAX_COLS > CNT_MAX) ? CNT_MAX : MAX_COLS;

    // configuration registers
    logic [CNT_W-1:0] rows_reg;
    logic [CNT_W-1:0] cols_reg;
    logic [CNT_W-1:0] nrows;
    logic [CNT_W-1:0] ncols;
    logic             cfg_wr;

    // sequencer
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;

    // captured weight add
    logic [AW-1:0]           w_addr_reg;
    logic signed [VAL_W-1:0] w_val_reg;

    // memories and their ports
    logic signed [VAL_W-1:0] weight_mem [DEPTH];
    logic signed [VAL_W-1:0] vector_mem [MAX_COLS];
    logic                    w_we;
    logic [AW-1:0]           w_wa;
    logic signed [VAL_W-1:0] w_wd;
    logic [AW-1:0]           w_ra;
    logic                    v_we;

    // mac pipeline
    logic signed [VAL_W-1:0]  w_q_reg;
    logic signed [VAL_W-1:0]  v_q_reg;
    logic                     rd_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     issue;

    // output register
    logic                     m_valid_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic                     out_last_reg;
    logic                     out_free;
    logic                     out_load;

    logic s_accept;
    logic add_in_range;
    logic row_is_last;

    // effective counts, zero reads as one, large values clamp
    always_comb begin
        if (rows_reg == '0) begin
            nrows = CNT_W'(1);
        end else if (32'(rows_reg) > ROW_LIM) begin
            nrows = CNT_W'(ROW_LIM);
        end else begin
            nrows = rows_reg;
        end
        if (cols_reg == '0) begin
            ncols = CNT_W'(1);
        end else if (32'(cols_reg) > COL_LIM) begin
            ncols = CNT_W'(COL_LIM);
        end else begin
            ncols = cols_reg;
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROWS: rows_reg <= pwdata[CNT_W-1:0];
                REG_COLS: cols_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = APB_DW'(rows_reg);
            REG_COLS: prdata = APB_DW'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // handshake helpers
    assign s_accept     = s_valid && s_ready;
    assign add_in_range = (CNT_W'(s_row_index) < nrows) && (CNT_W'(s_col_index) < ncols);
    assign row_is_last  = (row_reg == nrows - CNT_W'(1));
    assign out_free     = !m_valid_reg || m_ready;

    // next state and counters
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_command == CMD_WEIGHT_ADD && add_in_range) begin
                        state_next = ST_WWR;
                    end else if (s_command == CMD_VECTOR_LOAD && s_vector_last) begin
                        state_next = ST_MAC;
                        row_next   = '0;
                        col_next   = '0;
                    end
                end
            end
            ST_WWR: begin
                state_next = ST_IDLE;
            end
            ST_MAC: begin
                col_next = col_reg + CNT_W'(1);
                if (col_reg == ncols - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !prod_vld_reg) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    if (row_is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_MAC;
                        row_next   = row_reg + CNT_W'(1);
                        col_next   = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready  = 1'b0;
        w_we     = 1'b0;
        w_wa     = w_addr_reg;
        w_wd     = '0;
        w_ra     = AW'(32'(row_reg) * MAX_COLS + 32'(col_reg));
        v_we     = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                w_we = 1'b1;
                w_wa = clr_addr_reg;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                w_ra    = AW'(32'(s_row_index) * MAX_COLS + 32'(s_col_index));
                v_we    = s_accept && (s_command == CMD_VECTOR_LOAD)
                          && (CNT_W'(s_col_index) < ncols);
            end
            ST_WWR: begin
                w_we = 1'b1;
                w_wd = sat16(17'(w_q_reg) + 17'(w_val_reg));
            end
            ST_MAC: begin
                issue = 1'b1;
            end
            ST_DRAIN: ;
            ST_PUSH: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    // capture the weight add item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            w_addr_reg <= AW'(32'(s_row_index) * MAX_COLS + 32'(s_col_index));
            w_val_reg  <= s_value;
        end
    end

    // weight memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (w_we) begin
            weight_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge aclk) begin
        w_q_reg <= weight_mem[w_ra];
    end

    // vector memory
    always_ff @(posedge aclk) begin
        if (v_we) begin
            vector_mem[CW'(s_col_index)] <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        v_q_reg <= vector_mem[CW'(col_reg)];
    end

    // mac pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // multiply, then accumulate; at most 127 columns keeps the sum inside 40 bits
    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= w_q_reg * v_q_reg;
        end
        if (state_reg != ST_MAC && state_next == ST_MAC) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg   <= row_reg[ROW_W-1:0];
            out_value_reg <= acc_reg;
            out_last_reg  <= row_is_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_value = out_value_reg;
    assign m_out_last  = out_last_reg;

    // checks
    `MVM_ASSERT(a_row_bound, state_reg == ST_MAC, row_reg < nrows, "row counter past rows in use")
    `MVM_ASSERT(a_col_bound, state_reg == ST_MAC, col_reg < ncols,
        "column counter past columns in use")
    `MVM_ASSERT(a_load_from_push, $rose(m_valid), $past(state_reg) == ST_PUSH,
        "result appeared outside the push step")
    `MVM_ASSERT_NEXT(a_add_writes, s_accept && s_command == CMD_WEIGHT_ADD && add_in_range,
        state_reg == ST_WWR, "weight add did not reach write back")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// one row of the expected output vector
typedef struct {
    logic [mvm_pkg::ROW_W-1:0]        row;
    logic signed [mvm_pkg::ACC_W-1:0] value;
    logic                             last_flag;
} dot_result_t;

// tracks weights, vector and sizes, and checks each row result in order
class dot_product_checker;
    logic signed [mvm_pkg::VAL_W-1:0] weight_mem [mvm_pkg::MAX_ROWS_DEF][mvm_pkg::MAX_COLS_DEF];
    logic signed [mvm_pkg::VAL_W-1:0] vector_mem [mvm_pkg::MAX_COLS_DEF];
    bit                               vector_loaded [mvm_pkg::MAX_COLS_DEF];
    logic [mvm_pkg::CNT_W-1:0]        rows_reg;
    logic [mvm_pkg::CNT_W-1:0]        cols_reg;
    dot_result_t                      expected_dots [$];
    int                               mismatches;

    function new();
        for (int r = 0; r < mvm_pkg::MAX_ROWS_DEF; r++) begin
            for (int c = 0; c < mvm_pkg::MAX_COLS_DEF; c++) begin
                weight_mem[r][c] = '0;
            end
        end
        for (int c = 0; c < mvm_pkg::MAX_COLS_DEF; c++) begin
            vector_mem[c] = '0;
            vector_loaded[c] = 1'b0;
        end
        rows_reg = mvm_pkg::ROWS_RESET;
        cols_reg = mvm_pkg::COLS_RESET;
        mismatches = 0;
    endfunction

    // zero counts as one, anything past the storage counts as the storage size
    function int clamp_count(logic [mvm_pkg::CNT_W-1:0] raw, int limit);
        if (raw == '0) begin
            return 1;
        end
        return (int'(raw) > limit) ? limit : int'(raw);
    endfunction

    function int row_count();
        return clamp_count(rows_reg, mvm_pkg::MAX_ROWS_DEF);
    endfunction

    function int col_count();
        return clamp_count(cols_reg, mvm_pkg::MAX_COLS_DEF);
    endfunction

    function int pending();
        return expected_dots.size();
    endfunction

    // every vector element in use has been written since reset
    function bit all_loaded();
        for (int c = 0; c < col_count(); c++) begin
            if (!vector_loaded[c]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function void note_config(logic idx, logic [mvm_pkg::APB_DW-1:0] data);
        if (idx == mvm_pkg::REG_ROWS) begin
            rows_reg = data[mvm_pkg::CNT_W-1:0];
        end else if (idx == mvm_pkg::REG_COLS) begin
            cols_reg = data[mvm_pkg::CNT_W-1:0];
        end
    endfunction

    // update state for an accepted item; returns 0 when the block ignores it
    function bit note_item(logic cmd, logic [mvm_pkg::ROW_W-1:0] row,
                           logic [mvm_pkg::COL_W-1:0] col,
                           logic signed [mvm_pkg::VAL_W-1:0] val, logic last_flag);
        int          nrows;
        int          ncols;
        int          sum;
        longint      acc;
        dot_result_t dot;
        nrows = row_count();
        ncols = col_count();
        // saturating weight accumulate
        if (cmd == mvm_pkg::CMD_WEIGHT_ADD) begin
            if (int'(row) >= nrows || int'(col) >= ncols) begin
                return 1'b0;
            end
            sum = int'(weight_mem[row][col]) + int'(val);
            if (sum > 32767) begin
                sum = 32767;
            end else if (sum < -32768) begin
                sum = -32768;
            end
            weight_mem[row][col] = mvm_pkg::VAL_W'(sum);
            return 1'b1;
        end
        if (int'(col) < ncols) begin
            vector_mem[col] = val;
            vector_loaded[col] = 1'b1;
        end else if (!last_flag) begin
            return 1'b0;
        end
        // exact dot product per row, clamped to 40 bits
        if (last_flag) begin
            for (int r = 0; r < nrows; r++) begin
                acc = 0;
                for (int c = 0; c < ncols; c++) begin
                    acc += longint'(weight_mem[r][c]) * longint'(vector_mem[c]);
                end
                if (acc > 40'sh7f_ffff_ffff) begin
                    acc = 40'sh7f_ffff_ffff;
                end else if (acc < 40'sh80_0000_0000) begin
                    acc = 40'sh80_0000_0000;
                end
                dot.row = mvm_pkg::ROW_W'(r);
                dot.value = mvm_pkg::ACC_W'(acc);
                dot.last_flag = (r == nrows - 1);
                expected_dots.push_back(dot);
            end
        end
        return 1'b1;
    endfunction

    function void check_result(logic [mvm_pkg::ROW_W-1:0] row,
                               logic signed [mvm_pkg::ACC_W-1:0] value, logic last_flag);
        dot_result_t want;
        if (expected_dots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: row %0d value %0d last %0b",
                         row, value, last_flag);
            end
            return;
        end
        want = expected_dots.pop_front();
        if (row !== want.row || value !== want.value || last_flag !== want.last_flag) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected row %0d value %0d last %0b, got row %0d value %0d last %0b",
                         want.row, want.value, want.last_flag, row, value, last_flag);
            end
        end
    endfunction
endclass

module testbench;
    import mvm_pkg::*;

    localparam int ITEM_TARGET   = 350;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 16;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_command = 1'b0;
    logic [ROW_W-1:0]         s_row_index = '0;
    logic [COL_W-1:0]         s_col_index = '0;
    logic signed [VAL_W-1:0]  s_value = '0;
    logic                     s_vector_last = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [ROW_W-1:0]         m_out_row;
    logic signed [ACC_W-1:0]  m_out_value;
    logic                     m_out_last;

    dot_product_checker sb = new();
    int items_sent = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 60;
    int cycle_count = 0;

    matrix_vector_multiply dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_row_index   (s_row_index),
        .s_col_index   (s_col_index),
        .s_value       (s_value),
        .s_vector_last (s_vector_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_value   (m_out_value),
        .m_out_last    (m_out_last)
    );

    always #5 aclk = ~aclk;

    // result side: check accepted rows, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_out_row, m_out_value, m_out_last);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix_vector_multiply test failed");
            $finish;
        end
    end

    // setup cycle then access cycle; psel stays up for back-to-back writes
    task automatic write_reg(logic idx, logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.note_config(idx, data);
    endtask

    // register word, sometimes with junk above the count field
    function automatic logic [APB_DW-1:0] config_word(int unsigned raw);
        logic [APB_DW-1:0] word;
        word = APB_DW'(raw) & 32'h7f;
        if ($urandom_range(3) == 0) begin
            word |= $urandom & ~32'h7f;
        end
        return word;
    endfunction

    task automatic apply_config(int unsigned rows_raw, int unsigned cols_raw);
        write_reg(REG_ROWS, config_word(rows_raw));
        write_reg(REG_COLS, config_word(cols_raw));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop sending and wait for the block to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(logic cmd, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic signed [VAL_W-1:0] val, logic last_flag);
        // idle mix follows run progress
        if (items_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 60;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 60;
            recv_idle_pct = 24;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_row_index <= row;
        s_col_index <= col;
        s_value <= val;
        s_vector_last <= last_flag;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_item(cmd, row, col, val, last_flag)) begin
            items_sent++;
        end
    endtask

    // extremes, near-zero values and raw random
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return VAL_W'(int'($urandom_range(16)) - 8);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // count register value, mostly small so multiplies stay short
    function automatic int unsigned pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return 0;
        end else if (roll < 14) begin
            return MAX_ROWS_DEF;
        end else if (roll < 18) begin
            return $urandom_range(127, 65);
        end else if (roll < 24) begin
            return $urandom_range(63, 9);
        end
        return $urandom_range(8, 1);
    endfunction

    task automatic weight_item(bit anywhere);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        if (anywhere) begin
            row = ROW_W'($urandom);
            col = COL_W'($urandom);
        end else begin
            row = ROW_W'($urandom_range(sb.row_count() - 1));
            col = COL_W'($urandom_range(sb.col_count() - 1));
        end
        send_item(CMD_WEIGHT_ADD, row, col, rand_value(), 1'($urandom_range(1)));
    endtask

    // stray adds and loads; a stray last only once the vector is fully written
    task automatic noise_item();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            weight_item(1'b1);
        end else begin
            send_item(CMD_VECTOR_LOAD, ROW_W'($urandom), COL_W'($urandom), rand_value(),
                      roll >= 85 && sb.row_count() <= 8 && sb.all_loaded());
        end
    endtask

    // some weight updates, then every column once in shuffled order, last on the final one
    task automatic vector_pass();
        int order [MAX_COLS_DEF];
        int ncols;
        int pick;
        int tmp;
        ncols = sb.col_count();
        repeat ($urandom_range(6)) weight_item($urandom_range(4) == 0);
        for (int c = 0; c < ncols; c++) begin
            order[c] = c;
        end
        for (int c = ncols - 1; c > 0; c--) begin
            pick = $urandom_range(c);
            tmp = order[c];
            order[c] = order[pick];
            order[pick] = tmp;
        end
        for (int c = 0; c < ncols; c++) begin
            if ($urandom_range(99) < 12) begin
                noise_item();
            end
            send_item(CMD_VECTOR_LOAD, ROW_W'($urandom), COL_W'(order[c]), rand_value(),
                      c == ncols - 1);
        end
    endtask

    task automatic run_directed();
        apply_config(4, 4);
        // weight saturation both ways, vector_last ignored on an add
        send_item(CMD_WEIGHT_ADD, 6'd0, 6'd0, 16'sh7fff, 1'b0);
        send_item(CMD_WEIGHT_ADD, 6'd0, 6'd0, 16'sh0001, 1'b1);
        send_item(CMD_WEIGHT_ADD, 6'd1, 6'd1, 16'sh8000, 1'b0);
        send_item(CMD_WEIGHT_ADD, 6'd1, 6'd1, 16'sh8000, 1'b0);
        send_item(CMD_WEIGHT_ADD, 6'd2, 6'd3, 16'sh1234, 1'b0);
        send_item(CMD_WEIGHT_ADD, 6'd3, 6'd0, -16'sd1, 1'b0);
        send_item(CMD_WEIGHT_ADD, 6'd3, 6'd2, -16'sd12345, 1'b0);
        // adds outside the rows or columns in use
        send_item(CMD_WEIGHT_ADD, 6'd63, 6'd0, 16'sd555, 1'b0);
        send_item(CMD_WEIGHT_ADD, 6'd0, 6'd63, 16'sd777, 1'b0);
        // vector extremes, row field ignored
        send_item(CMD_VECTOR_LOAD, 6'd0, 6'd0, 16'sh7fff, 1'b0);
        send_item(CMD_VECTOR_LOAD, 6'd63, 6'd1, 16'sh8000, 1'b0);
        send_item(CMD_VECTOR_LOAD, 6'd5, 6'd2, -16'sd1, 1'b0);
        send_item(CMD_VECTOR_LOAD, 6'd0, 6'd3, 16'sd1, 1'b0);
        // last element outside the columns in use still runs the multiply
        send_item(CMD_VECTOR_LOAD, 6'd0, 6'd63, 16'sd1000, 1'b1);
        send_item(CMD_VECTOR_LOAD, 6'd0, 6'd3, 16'sh8000, 1'b1);
        // zero counts read as one row and one column
        settle();
        apply_config(0, 0);
        send_item(CMD_WEIGHT_ADD, 6'd0, 6'd1, 16'sd99, 1'b0);
        send_item(CMD_VECTOR_LOAD, 6'd0, 6'd0, 16'sh8000, 1'b1);
    endtask

    task automatic run_random();
        int unsigned rows_raw;
        int unsigned cols_raw;
        bit          first;
        first = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            // oversized counts clamp to the full matrix
            if (first) begin
                rows_raw = 127;
                cols_raw = 127;
            end else begin
                rows_raw = pick_count();
                cols_raw = pick_count();
            end
            settle();
            apply_config(rows_raw, cols_raw);
            if (first) begin
                vector_pass();
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    if (items_sent < ITEM_TARGET) begin
                        vector_pass();
                    end
                end
            end
            first = 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("matrix_vector_multiply test passed");
        end else begin
            $display("matrix_vector_multiply test failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mvm_pkg.sv
hw/rtl/matrix_vector_multiply.sv
dv/testbench.sv
